// ===== rtl/bas_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the button auto-repeat scanner
package bas_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int PIN_W       = 4;
   localparam int CNT_W       = 16;
   localparam int NUM_W       = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   // buttons that show up in the masks
   localparam int MASK_LANES  = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;
   localparam int SUM_BASE_W  = $clog2(NUM_BUTTONS + 1);
   localparam int SUM_W       = (SUM_BASE_W > NUM_W) ? SUM_BASE_W : NUM_W;

   localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
   localparam logic [NUM_W-1:0] PRESSED_MAX = {NUM_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_TICKS  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_TICKS   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_TICKS  = 4'd3;

   typedef struct packed {
      logic [CNT_W-1:0] detect_ticks;
      logic [CNT_W-1:0] delay_ticks;
      logic [CNT_W-1:0] period_ticks;
   } timing_type;

   typedef struct packed {
      logic             held;
      logic             press;
      logic             release_evt;
      logic             repeat_evt;
      logic [CNT_W-1:0] repeat_count;
   } lane_status_type;

   typedef struct packed {
      logic [PIN_W-1:0] pressed_mask;
      logic [PIN_W-1:0] press_edge_mask;
      logic [PIN_W-1:0] release_edge_mask;
      logic [PIN_W-1:0] repeat_mask;
      logic [NUM_W-1:0] pressed_number;
      logic [CNT_W-1:0] first_repeat_count;
   } rsp_payload_type;

endpackage

// ===== rtl/bas_if.sv =====
`timescale 1ns / 1ps
// handshake channel interfaces of the button auto-repeat scanner
interface bas_req_if;
   logic                      valid;
   logic                      ready;
   logic [bas_pkg::PIN_W-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bas_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bas_pkg::PIN_W-1:0] pressed_mask;
   logic [bas_pkg::PIN_W-1:0] press_edge_mask;
   logic [bas_pkg::PIN_W-1:0] release_edge_mask;
   logic [bas_pkg::PIN_W-1:0] repeat_mask;
   logic [bas_pkg::NUM_W-1:0] pressed_number;
   logic [bas_pkg::CNT_W-1:0] first_repeat_count;

   modport source (output valid, output pressed_mask, output press_edge_mask,
                   output release_edge_mask, output repeat_mask,
                   output pressed_number, output first_repeat_count, input ready);
   modport sink   (input valid, input pressed_mask, input press_edge_mask,
                   input release_edge_mask, input repeat_mask,
                   input pressed_number, input first_repeat_count, output ready);
endinterface

interface bas_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bas_pkg::CSR_IDX_W-1:0]  index;
   logic [bas_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bas_lane.sv =====
`timescale 1ns / 1ps
// per-button lane: held flag, hold counter and repeat counter
module bas_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     clear_counters,
   input  logic                     active,
   input  bas_pkg::timing_type      timing,
   output bas_pkg::lane_status_type status
);

   logic                      held_ff, held_in;
   logic [bas_pkg::CNT_W-1:0] hold_ff, hold_in;
   logic [bas_pkg::CNT_W-1:0] rcount_ff, rcount_in;
   logic [bas_pkg::CNT_W-1:0] hold_inc;
   logic [bas_pkg::CNT_W-1:0] threshold;
   logic                      fire;

   always_comb begin
      hold_inc = (hold_ff != bas_pkg::CNT_MAX) ? hold_ff + bas_pkg::CNT_W'(1) : hold_ff;
      priority if (rcount_ff == '0) begin
         threshold = timing.detect_ticks;
      end else if (rcount_ff == bas_pkg::CNT_W'(1)) begin
         threshold = timing.delay_ticks;
      end else begin
         threshold = timing.period_ticks;
      end
      fire = active && (hold_inc >= threshold);

      if (active) begin
         held_in   = 1'b1;
         hold_in   = fire ? '0 : hold_inc;
         rcount_in = (fire && rcount_ff != bas_pkg::CNT_MAX) ?
                     rcount_ff + bas_pkg::CNT_W'(1) : rcount_ff;
      end else begin
         held_in   = 1'b0;
         hold_in   = '0;
         rcount_in = '0;
      end

      status.held         = held_in;
      status.press        = active && !held_ff;
      status.release_evt  = !active && held_ff;
      status.repeat_evt   = fire;
      status.repeat_count = rcount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         hold_ff   <= '0;
         rcount_ff <= '0;
      end else if (clear_counters) begin
         // timing change restarts every count, held flags stay
         hold_ff   <= '0;
         rcount_ff <= '0;
      end else if (step) begin
         held_ff   <= held_in;
         hold_ff   <= hold_in;
         rcount_ff <= rcount_in;
      end
   end

endmodule

// ===== rtl/bas_merge.sv =====
`timescale 1ns / 1ps
// merges lane results into masks, pressed count and button zero repeat count
module bas_merge (
   input  bas_pkg::lane_status_type lanes [bas_pkg::NUM_BUTTONS],
   input  logic                     output_enable,
   output bas_pkg::rsp_payload_type payload
);

   logic [bas_pkg::SUM_W-1:0] held_sum;
   logic [bas_pkg::PIN_W-1:0] held_mask;

   always_comb begin
      held_sum                  = '0;
      held_mask                 = '0;
      payload.press_edge_mask   = '0;
      payload.release_edge_mask = '0;
      payload.repeat_mask       = '0;
      for (int i = 0; i < bas_pkg::NUM_BUTTONS; i++) begin
         held_sum = held_sum + bas_pkg::SUM_W'(lanes[i].held);
      end
      for (int i = 0; i < bas_pkg::MASK_LANES; i++) begin
         held_mask[i]                 = lanes[i].held;
         payload.press_edge_mask[i]   = lanes[i].press;
         payload.release_edge_mask[i] = lanes[i].release_evt;
         payload.repeat_mask[i]       = lanes[i].repeat_evt;
      end

      if (output_enable) begin
         payload.pressed_mask = held_mask;
         payload.pressed_number = (held_sum > bas_pkg::SUM_W'(bas_pkg::PRESSED_MAX)) ?
                                  bas_pkg::PRESSED_MAX : held_sum[bas_pkg::NUM_W-1:0];
      end else begin
         payload.pressed_mask   = '0;
         payload.pressed_number = '0;
      end
      payload.first_repeat_count = lanes[0].repeat_count;
   end

endmodule

// ===== rtl/button_autorepeat_scanner_core.sv =====
`timescale 1ns / 1ps
// button auto-repeat scanner: all lanes update in parallel on each scan request
// a request's result is registered and shows valid in the cycle after it is accepted
// throughput: one request per cycle, lane update and merge sit in one stage
// a waiting result holds off requests; taking it frees the register that same cycle
// reset: held flags and counters clear, output_enable is 1, timings are 0
// csr writes are taken every cycle; a timing write clears all counters
module button_autorepeat_scanner_core (
   input  logic       clock,
   input  logic       reset,
   bas_req_if.sink    req_ch,
   bas_rsp_if.source  rsp_ch,
   bas_csr_if.sink    csr_ch
);

   logic                     out_enable_ff, out_enable_in;
   bas_pkg::timing_type      timing_ff, timing_in;
   logic                     clear_counters;
   logic                     csr_write;
   logic                     step;
   logic                     rsp_valid_ff, rsp_valid_in;
   bas_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   bas_pkg::lane_status_type lanes [bas_pkg::NUM_BUTTONS];

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   always_comb begin
      out_enable_in  = out_enable_ff;
      timing_in      = timing_ff;
      clear_counters = 1'b0;
      if (csr_write) begin
         unique case (csr_ch.index)
            bas_pkg::REG_OUTPUT_ENABLE: out_enable_in = csr_ch.data[0];
            bas_pkg::REG_DETECT_TICKS: begin
               timing_in.detect_ticks = csr_ch.data;
               clear_counters         = 1'b1;
            end
            bas_pkg::REG_DELAY_TICKS: begin
               timing_in.delay_ticks = csr_ch.data;
               clear_counters        = 1'b1;
            end
            bas_pkg::REG_PERIOD_TICKS: begin
               timing_in.period_ticks = csr_ch.data;
               clear_counters         = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_enable_ff <= 1'b1;
         timing_ff     <= '0;
      end else begin
         out_enable_ff <= out_enable_in;
         timing_ff     <= timing_in;
      end
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign step         = req_ch.valid && req_ch.ready;

   for (genvar i = 0; i < bas_pkg::NUM_BUTTONS; i++) begin : g_lane
      logic lane_active;
      if (i < bas_pkg::PIN_W) begin : g_pin
         assign lane_active = req_ch.pin_levels[i];
      end else begin : g_nopin
         // no input bit for this button, it never goes active
         assign lane_active = 1'b0;
      end
      bas_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .step           (step),
         .clear_counters (clear_counters),
         .active         (lane_active),
         .timing         (timing_ff),
         .status         (lanes[i])
      );
   end

   bas_merge u_merge (
      .lanes         (lanes),
      .output_enable (out_enable_ff),
      .payload       (rsp_data_in)
   );

   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.pressed_mask       = rsp_data_ff.pressed_mask;
   assign rsp_ch.press_edge_mask    = rsp_data_ff.press_edge_mask;
   assign rsp_ch.release_edge_mask  = rsp_data_ff.release_edge_mask;
   assign rsp_ch.repeat_mask        = rsp_data_ff.repeat_mask;
   assign rsp_ch.pressed_number     = rsp_data_ff.pressed_number;
   assign rsp_ch.first_repeat_count = rsp_data_ff.first_repeat_count;

endmodule
